// ----- rtl/core/wab_pkg.sv -----
`timescale 1ns / 1ps

package wab_pkg;

    typedef enum logic [2:0] {
        ACT_LOAD_PT  = 3'd0,
        ACT_LOAD_NRM = 3'd1,
        ACT_POINT    = 3'd2,
        ACT_VECTOR   = 3'd3,
        ACT_NORMAL   = 3'd4
    } t_action;

    localparam logic [1:0] CFG_ADD_INPUT   = 2'd0;
    localparam logic [1:0] CFG_ACTIVE_MASK = 2'd1;

    localparam int MAX_LANES  = 4;
    localparam int PT_COEFS   = 12;
    localparam int NRM_COEFS  = 9;
    localparam int PT_STRIDE  = 4;
    localparam int NRM_STRIDE = 3;

    localparam int SQ_STEPS     = 32;
    localparam int SQ_PER_STG   = 2;
    localparam int SQ_STAGES    = SQ_STEPS / SQ_PER_STG;
    localparam int DIV_STEPS    = 17;
    localparam int DIV_PER_STG  = 3;
    localparam int DIV_STAGES   = (DIV_STEPS + DIV_PER_STG - 1) / DIV_PER_STG;

    typedef struct packed {
        logic [63:0] n;
        logic [63:0] r;
    } t_isq;

    typedef struct packed {
        logic [48:0] rem;
        logic [16:0] q;
    } t_div;

    typedef struct packed {
        logic             valid;
        t_action          act;
        logic [2:0][31:0] v;
        logic [3:0][15:0] w;
    } t_blend_side;

    function automatic logic signed [47:0] rnd16(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd32768;
        return t[63:16];
    endfunction

    function automatic logic signed [33:0] rnd14(input logic signed [47:0] p);
        logic signed [47:0] t;
        t = p + 48'sd8192;
        return t[47:14];
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) begin
            return 32'h7FFF_FFFF;
        end else if (v < -64'sh8000_0000) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // one digit of the integer square root
    function automatic t_isq isq_step(input t_isq s, input int unsigned j);
        logic [63:0] b;
        logic [63:0] t;
        t_isq o;
        b = 64'd1 << (2 * j);
        t = s.r + b;
        if (s.n >= t) begin
            o.n = s.n - t;
            o.r = (s.r >> 1) + b;
        end else begin
            o.n = s.n;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    // one quotient bit of restoring division
    function automatic t_div div_step(input t_div s, input logic [31:0] len,
                                      input int unsigned i);
        logic [48:0] d;
        t_div o;
        d = {17'd0, len} << i;
        o = s;
        if (s.rem >= d) begin
            o.rem  = s.rem - d;
            o.q[i] = 1'b1;
        end
        return o;
    endfunction

endpackage

// ----- rtl/core/wab_nrm.sv -----
`timescale 1ns / 1ps

module wab_nrm import wab_pkg::*; #(
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_go,
    input  logic [LANES-1:0][2:0][31:0]   i_v,
    input  logic [SIDE_W-1:0]             i_side,
    output logic [LANES-1:0][2:0][31:0]   o_v,
    output logic [SIDE_W-1:0]             o_side
);

    localparam int ST_SQ0  = 2;
    localparam int ST_D    = ST_SQ0 + SQ_STAGES;
    localparam int ST_DIV0 = ST_D + 1;
    localparam int ST_OUT  = ST_DIV0 + DIV_STAGES;
    localparam int NST     = ST_OUT + 1;

    typedef struct packed {
        logic                        go;
        logic [SIDE_W-1:0]           side;
        logic [LANES-1:0][2:0][31:0] v;
        logic [LANES-1:0][2:0][31:0] a;
        logic [LANES-1:0][2:0]       neg;
    } t_carry;

    t_carry      c_in;
    t_carry      r_cr   [NST];
    logic [63:0] r_sq   [LANES][3];
    logic [63:0] r_n0   [LANES];
    t_isq        r_isq  [SQ_STAGES][LANES];
    t_isq        n_isq  [SQ_STAGES][LANES];
    t_div        r_dv0  [LANES][3];
    logic [31:0] r_len0 [LANES];
    t_div        r_dv   [DIV_STAGES][LANES][3];
    t_div        n_dv   [DIV_STAGES][LANES][3];
    logic [31:0] r_len  [DIV_STAGES][LANES];
    logic [LANES-1:0][2:0][31:0] r_out;

    always_comb begin
        c_in.go   = i_go;
        c_in.side = i_side;
        c_in.v    = i_v;
        for (int l = 0; l < LANES; l++) begin
            for (int c = 0; c < 3; c++) begin
                c_in.neg[l][c] = i_v[l][c][31];
                c_in.a[l][c]   = i_v[l][c][31] ? (~i_v[l][c] + 32'd1) : i_v[l][c];
            end
        end
    end

    always_comb begin
        t_isq x;
        t_div y;
        for (int s = 0; s < SQ_STAGES; s++) begin
            for (int l = 0; l < LANES; l++) begin
                if (s == 0) begin
                    x.n = r_n0[l];
                    x.r = '0;
                end else begin
                    x = r_isq[s-1][l];
                end
                for (int st = 0; st < SQ_PER_STG; st++) begin
                    x = isq_step(x, SQ_STEPS - 1 - s * SQ_PER_STG - st);
                end
                n_isq[s][l] = x;
            end
        end
        for (int d = 0; d < DIV_STAGES; d++) begin
            for (int l = 0; l < LANES; l++) begin
                for (int c = 0; c < 3; c++) begin
                    y = (d == 0) ? r_dv0[l][c] : r_dv[d-1][l][c];
                    for (int st = 0; st < DIV_PER_STG; st++) begin
                        if (DIV_STEPS - 1 - d * DIV_PER_STG - st >= 0) begin
                            y = div_step(y, (d == 0) ? r_len0[l] : r_len[d-1][l],
                                         DIV_STEPS - 1 - d * DIV_PER_STG - st);
                        end
                    end
                    n_dv[d][l][c] = y;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) begin
                r_cr[s] <= '0;
            end
        end else if (i_en) begin
            r_cr[0] <= c_in;
            for (int s = 1; s < NST; s++) begin
                r_cr[s] <= r_cr[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                for (int c = 0; c < 3; c++) begin
                    r_sq[l][c] <= c_in.a[l][c] * c_in.a[l][c];
                end
                r_n0[l] <= r_sq[l][0] + r_sq[l][1] + r_sq[l][2];
                for (int s = 0; s < SQ_STAGES; s++) begin
                    r_isq[s][l] <= n_isq[s][l];
                end
                r_len0[l] <= r_isq[SQ_STAGES-1][l].r[31:0];
                for (int c = 0; c < 3; c++) begin
                    r_dv0[l][c].rem <= {1'b0, r_cr[ST_D-1].a[l][c], 16'd0}
                                     + {17'd0, 1'b0, r_isq[SQ_STAGES-1][l].r[31:1]};
                    r_dv0[l][c].q   <= '0;
                end
                for (int d = 0; d < DIV_STAGES; d++) begin
                    r_len[d][l] <= (d == 0) ? r_len0[l] : r_len[d-1][l];
                    for (int c = 0; c < 3; c++) begin
                        r_dv[d][l][c] <= n_dv[d][l][c];
                    end
                end
                for (int c = 0; c < 3; c++) begin
                    if (r_cr[ST_OUT-1].go && (r_len[DIV_STAGES-1][l] != '0)) begin
                        r_out[l][c] <= r_cr[ST_OUT-1].neg[l][c]
                            ? (~{15'd0, r_dv[DIV_STAGES-1][l][c].q} + 32'd1)
                            : {15'd0, r_dv[DIV_STAGES-1][l][c].q};
                    end else begin
                        r_out[l][c] <= r_cr[ST_OUT-1].v[l][c];
                    end
                end
            end
        end
    end

    assign o_v    = r_out;
    assign o_side = r_cr[ST_OUT].side;

endmodule

// ----- rtl/core/weighted_affine_blend_core.sv -----
`timescale 1ns / 1ps
// channel   dir   handshake                     payload
// input     in    i_valid / o_stall             i_action i_slot i_x i_y i_z i_weight_0..3
// output    out   o_valid / i_stall             o_out_x o_out_y o_out_z
// config    in    i_cfg_valid / o_cfg_ready     i_cfg_index i_cfg_data
//
// one beat per cycle while the output is not stalled; results come out in order
// the path runs through two normalize units (26 stages each: 2-bit root steps,
// 3-bit quotient steps) plus 5 transform and blend stages
// loads write at acceptance; loads and unused actions leave a bubble
// reset is synchronous and clears config, both matrices and all valid bits
// a stalled output freezes the whole pipeline; o_stall follows it in the same cycle

module weighted_affine_blend_core import wab_pkg::*; #(
    parameter int NUM_TRANSFORMS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_action,
    input  logic [5:0]  i_slot,
    input  logic [31:0] i_x,
    input  logic [31:0] i_y,
    input  logic [31:0] i_z,
    input  logic [15:0] i_weight_0,
    input  logic [15:0] i_weight_1,
    input  logic [15:0] i_weight_2,
    input  logic [15:0] i_weight_3,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_out_x,
    output logic [31:0] o_out_y,
    output logic [31:0] o_out_z,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int LANES     = (NUM_TRANSFORMS < MAX_LANES) ? NUM_TRANSFORMS : MAX_LANES;
    localparam int PT_DEPTH  = LANES * PT_COEFS;
    localparam int NRM_DEPTH = LANES * NRM_COEFS;
    localparam int SIDE_W    = $bits(t_blend_side);

    logic en;
    logic in_acc;
    logic is_compute;

    logic       r_add_input;
    logic [3:0] r_active_mask;

    logic signed [31:0] r_pt  [PT_DEPTH];
    logic signed [31:0] r_nrm [NRM_DEPTH];

    logic             r0_valid;
    t_action          r0_act;
    logic [2:0][31:0] r0_v;
    logic [3:0][15:0] r0_w;

    logic signed [31:0] c1_coef [LANES][3][3];
    logic signed [31:0] c1_tr   [LANES][3];
    logic               r1_valid;
    t_action            r1_act;
    logic [2:0][31:0]   r1_v;
    logic [3:0][15:0]   r1_w;
    logic signed [63:0] r1_p    [LANES][3][3];
    logic signed [31:0] r1_tr   [LANES][3];

    logic signed [63:0]          s2_sum [LANES][3];
    t_blend_side                 r2_side;
    logic [LANES-1:0][2:0][31:0] r2_t;

    logic [LANES-1:0][2:0][31:0] n1_t;
    logic [SIDE_W-1:0]           n1_raw;
    t_blend_side                 n1_side;

    logic               r3_valid;
    logic               r3_nrm;
    logic [2:0][31:0]   r3_v;
    logic signed [33:0] r3_wt [LANES][3];

    logic signed [63:0]    s4_acc [3];
    logic                  r4_valid;
    logic                  r4_nrm;
    logic [0:0][2:0][31:0] r4_acc;

    logic [0:0][2:0][31:0] n2_v;
    logic [1:0]            n2_side;
    logic                  out_nrm;

    assign en          = !(o_valid && i_stall);
    assign o_stall     = !en;
    assign in_acc      = i_valid && en;
    assign o_cfg_ready = 1'b1;
    assign is_compute  = (i_action == ACT_POINT) || (i_action == ACT_VECTOR)
                      || (i_action == ACT_NORMAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add_input   <= 1'b0;
            r_active_mask <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ADD_INPUT:   r_add_input   <= i_cfg_data[0];
                CFG_ACTIVE_MASK: r_active_mask <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < PT_DEPTH; e++) begin
                r_pt[e] <= '0;
            end
            for (int e = 0; e < NRM_DEPTH; e++) begin
                r_nrm[e] <= '0;
            end
        end else if (in_acc) begin
            for (int e = 0; e < PT_DEPTH; e++) begin
                if ((i_action == ACT_LOAD_PT) && (i_slot == 6'(e))) begin
                    r_pt[e] <= i_x;
                end
            end
            for (int e = 0; e < NRM_DEPTH; e++) begin
                if ((i_action == ACT_LOAD_NRM) && (i_slot == 6'(e))) begin
                    r_nrm[e] <= i_x;
                end
            end
        end
    end

    // stage 0: input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (en) begin
            r0_valid <= in_acc && is_compute;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_act <= t_action'(i_action);
            r0_v   <= {i_z, i_y, i_x};
            r0_w   <= {i_weight_3, i_weight_2, i_weight_1, i_weight_0};
        end
    end

    // stage 1: coefficient products
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    c1_coef[k][r][c] = (r0_act == ACT_NORMAL)
                        ? r_nrm[k * NRM_COEFS + r * NRM_STRIDE + c]
                        : r_pt[k * PT_COEFS + r * PT_STRIDE + c];
                end
                c1_tr[k][r] = (r0_act == ACT_POINT)
                    ? r_pt[k * PT_COEFS + r * PT_STRIDE + PT_STRIDE - 1] : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= r0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_act <= r0_act;
            r1_v   <= r0_v;
            r1_w   <= r0_w;
            for (int k = 0; k < LANES; k++) begin
                for (int r = 0; r < 3; r++) begin
                    for (int c = 0; c < 3; c++) begin
                        r1_p[k][r][c] <= c1_coef[k][r][c] * $signed(r0_v[c]);
                    end
                    r1_tr[k][r] <= c1_tr[k][r];
                end
            end
        end
    end

    // stage 2: row sums
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            for (int r = 0; r < 3; r++) begin
                s2_sum[k][r] = 64'(rnd16(r1_p[k][r][0])) + 64'(rnd16(r1_p[k][r][1]))
                             + 64'(rnd16(r1_p[k][r][2])) + 64'(r1_tr[k][r]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_side.valid <= 1'b0;
        end else if (en) begin
            r2_side.valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_side.act <= r1_act;
            r2_side.v   <= r1_v;
            r2_side.w   <= r1_w;
            for (int k = 0; k < LANES; k++) begin
                for (int r = 0; r < 3; r++) begin
                    r2_t[k][r] <= sat32(s2_sum[k][r]);
                end
            end
        end
    end

    wab_nrm #(
        .LANES  (LANES),
        .SIDE_W (SIDE_W)
    ) u_nrm_lane (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_go    (r2_side.act == ACT_NORMAL),
        .i_v     (r2_t),
        .i_side  (r2_side),
        .o_v     (n1_t),
        .o_side  (n1_raw)
    );

    assign n1_side = t_blend_side'(n1_raw);

    // stage 3: weighting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= n1_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_nrm <= (n1_side.act == ACT_NORMAL);
            r3_v   <= n1_side.v;
            for (int k = 0; k < LANES; k++) begin
                for (int r = 0; r < 3; r++) begin
                    r3_wt[k][r] <= r_active_mask[k]
                        ? rnd14(48'($signed(n1_t[k][r])) * 48'($signed(n1_side.w[k])))
                        : '0;
                end
            end
        end
    end

    // stage 4: accumulate
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            s4_acc[r] = r_add_input ? 64'($signed(r3_v[r])) : 64'sd0;
            for (int k = 0; k < LANES; k++) begin
                s4_acc[r] = s4_acc[r] + 64'(r3_wt[k][r]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_nrm <= r3_nrm;
            for (int r = 0; r < 3; r++) begin
                r4_acc[0][r] <= sat32(s4_acc[r]);
            end
        end
    end

    wab_nrm #(
        .LANES  (1),
        .SIDE_W (2)
    ) u_nrm_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_go    (r4_nrm),
        .i_v     (r4_acc),
        .i_side  ({r4_valid, r4_nrm}),
        .o_v     (n2_v),
        .o_side  (n2_side)
    );

    assign o_valid = n2_side[1];
    assign out_nrm = n2_side[0];
    assign o_out_x = n2_v[0][0];
    assign o_out_y = n2_v[0][1];
    assign o_out_z = n2_v[0][2];

    a_s0_compute_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r0_valid |-> ((r0_act == ACT_POINT) || (r0_act == ACT_VECTOR)
                   || (r0_act == ACT_NORMAL)))
        else $error("non-compute action entered the pipeline");

    a_idle_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output");

    a_normal_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && out_nrm) |->
            ($signed(o_out_x) <= 32'sd65536 && $signed(o_out_x) >= -32'sd65536
          && $signed(o_out_y) <= 32'sd65536 && $signed(o_out_y) >= -32'sd65536
          && $signed(o_out_z) <= 32'sd65536 && $signed(o_out_z) >= -32'sd65536))
        else $error("normalized result out of unit range");

endmodule
